/* rtl/segmin_pkg.sv */
// ----------------------------------------------------------------------------
// segmin_pkg
// Shared widths, command codes and defaults for the segment tree range-min
// engine.
// ----------------------------------------------------------------------------
package segmin_pkg;

	localparam int TREE_LEAVES = 4096;

	localparam int VAL_W = 32;
	localparam int IDX_W = 12;
	localparam int CMD_W = 2;

	// packed input item: entry_index, lcp_value, range_low, range_high
	localparam int IN_FIELDS_W = IDX_W + VAL_W + IDX_W + IDX_W;
	localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((VAL_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};

endpackage

/* rtl/segment_tree_range_min.sv */
// ----------------------------------------------------------------------------
// segment_tree_range_min
// Range-minimum engine over a binary segment tree held in one node memory
// with a write port and two registered read ports.
// ----------------------------------------------------------------------------
// clear: a sweep over all 2*SPAN-1 nodes of the node memory (8191 for 4096 leaves)
// write: one sibling read per tree level, from the leaf up to the root
// query: two node reads per level; it finishes once the walk is done and no
// earlier result still waits on the output
// one item at a time; the registered memory reads put a compare state after each read
// reset runs the same clearing sweep before the first item is accepted
// ----------------------------------------------------------------------------
module segment_tree_range_min #(
	parameter int LEAVES = segmin_pkg::TREE_LEAVES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// entry_index[11:0], lcp_value[43:12], range_low[55:44], range_high[67:56]
	input  logic [segmin_pkg::IN_DATA_W-1:0] s_tdata,
	// cmd[1:0]
	input  logic [segmin_pkg::CMD_W-1:0]     s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// range_min[31:0]
	output logic [segmin_pkg::OUT_DATA_W-1:0] m_tdata
);
	import segmin_pkg::*;

	localparam int SPAN = 1 << $clog2(LEAVES);
	localparam int NODES = 2 * SPAN - 1;
	localparam int NA_W = $clog2(2 * SPAN);
	localparam int LR_W = NA_W + 1;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_WR   = 3'd2;
	localparam logic [2:0] ST_WCMP = 3'd3;
	localparam logic [2:0] ST_QRD  = 3'd4;
	localparam logic [2:0] ST_QACC = 3'd5;

	logic [2:0]       state_q;
	logic [NA_W-1:0]  clr_q;
	logic [NA_W-1:0]  cur_q;
	logic [VAL_W-1:0] val_q;
	logic [LR_W-1:0]  ql_q;
	logic [LR_W-1:0]  qr_q;
	logic [VAL_W-1:0] qm_q;
	logic             use_a_q;
	logic             use_b_q;
	logic             m_tvalid_q;
	logic [VAL_W-1:0] m_data_q;

	logic [VAL_W-1:0] mem [NODES];
	logic [VAL_W-1:0] rda_q;
	logic [VAL_W-1:0] rdb_q;

	logic             we;
	logic [NA_W-1:0]  waddr;
	logic [VAL_W-1:0] wdata;
	logic [NA_W-1:0]  raddr_a;
	logic [NA_W-1:0]  raddr_b;

	logic [IDX_W-1:0] entry_index;
	logic [VAL_W-1:0] lcp_value;
	logic [IDX_W-1:0] range_low;
	logic [IDX_W-1:0] range_high;
	logic             in_acc;
	logic [31:0]      idx32;
	logic [31:0]      lo32;
	logic [31:0]      hi32;
	logic [VAL_W-1:0] pick_a;
	logic [VAL_W-1:0] pick_b;
	logic [VAL_W-1:0] min_ab;
	logic             res_fire;

	assign entry_index = s_tdata[IDX_W-1:0];
	assign lcp_value   = s_tdata[IDX_W+VAL_W-1:IDX_W];
	assign range_low   = s_tdata[2*IDX_W+VAL_W-1:IDX_W+VAL_W];
	assign range_high  = s_tdata[3*IDX_W+VAL_W-1:2*IDX_W+VAL_W];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'(m_data_q);

	assign idx32 = 32'(entry_index);
	assign lo32  = 32'(range_low);
	// clip the top of the range to the last real leaf
	assign hi32  = (32'(range_high) >= 32'(LEAVES)) ? 32'(LEAVES - 1) : 32'(range_high);

	assign pick_a = use_a_q ? rda_q : ALL_ONES;
	assign pick_b = use_b_q ? rdb_q : ALL_ONES;
	assign min_ab = (pick_a < pick_b) ? pick_a : pick_b;

	// query walk done and the output register free to take its result
	assign res_fire = (state_q == ST_QRD) && (ql_q >= qr_q) && (!m_tvalid_q || m_tready);

	// memory port control
	always_comb begin
		we      = 1'b0;
		waddr   = cur_q;
		wdata   = val_q;
		// sibling of the current node during an update walk
		raddr_a = cur_q[0] ? (cur_q + NA_W'(1)) : (cur_q - NA_W'(1));
		raddr_b = NA_W'(qr_q - LR_W'(2));
		case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = ALL_ONES;
			end
			ST_WR: begin
				we = 1'b1;
			end
			ST_QRD: begin
				raddr_a = NA_W'(ql_q - LR_W'(1));
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rda_q <= mem[raddr_a];
		rdb_q <= mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (res_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					if (clr_q == NA_W'(NODES - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_q <= clr_q + NA_W'(1);
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (s_tuser)
							CMD_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
							CMD_WRITE: begin
								if (idx32 < 32'(LEAVES)) begin
									state_q <= ST_WR;
								end
							end
							CMD_QUERY: begin
								state_q <= ST_QRD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WR: begin
					state_q <= (cur_q == '0) ? ST_IDLE : ST_WCMP;
				end
				ST_WCMP: begin
					state_q <= ST_WR;
				end
				ST_QRD: begin
					if (ql_q < qr_q) begin
						state_q <= ST_QACC;
					end else if (res_fire) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QACC: begin
					state_q <= ST_QRD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk and query datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q <= NA_W'(32'(SPAN - 1) + idx32);
				val_q <= lcp_value;
				qm_q  <= ALL_ONES;
				if (lo32 > hi32) begin
					// empty range finishes at once
					ql_q <= '0;
					qr_q <= '0;
				end else begin
					ql_q <= LR_W'(lo32 + 32'(SPAN));
					qr_q <= LR_W'(hi32 + 32'(SPAN) + 32'd1);
				end
			end
			ST_WCMP: begin
				val_q <= (rda_q < val_q) ? rda_q : val_q;
				cur_q <= (cur_q - NA_W'(1)) >> 1;
			end
			ST_QRD: begin
				use_a_q <= ql_q[0];
				use_b_q <= qr_q[0];
				ql_q    <= (ql_q + LR_W'(ql_q[0])) >> 1;
				qr_q    <= (qr_q - LR_W'(qr_q[0])) >> 1;
				if (res_fire) begin
					m_data_q <= qm_q;
				end
			end
			ST_QACC: begin
				qm_q <= (min_ab < qm_q) ? min_ab : qm_q;
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

`ifndef SYNTH
	a_no_result_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser != CMD_QUERY) |=> !$rose(m_tvalid))
		else $error("result raised after a non-query item");

	a_clear_pass_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR && clr_q == NA_W'(NODES - 1)) |=> state_q == ST_IDLE)
		else $error("clearing pass did not end at the last node");

	a_walk_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WCMP) |-> cur_q != '0)
		else $error("update walk went above the root");

	a_query_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QACC) |-> ql_q <= qr_q)
		else $error("query bounds crossed");
`endif

endmodule
